>>> src/tmdq_pkg.sv
// Package for the timed message delay queue: opcodes, result kinds, register indexes,
// the command beat passed from the front end to the back end, and the back-end state type.
// No dependencies.
`default_nettype none

package tmdq_pkg;

	localparam int OPC_W   = 3;
	localparam int CLS_W   = 3;
	localparam int DEST_W  = 8;
	localparam int PAY_W   = 64;
	localparam int LAT_W   = 8;
	localparam int KIND_W  = 2;
	localparam int OCC_W   = 5;
	localparam int CNT_W   = 32;
	localparam int TIME_W  = 64;
	localparam int REGI_W  = 2;
	localparam int NUM_CLS = 5;

	localparam logic [OPC_W-1:0] OP_REQUEST  = 3'd0;
	localparam logic [OPC_W-1:0] OP_RESPONSE = 3'd1;
	localparam logic [OPC_W-1:0] OP_DATA     = 3'd2;
	localparam logic [OPC_W-1:0] OP_SNOOP    = 3'd3;
	localparam logic [OPC_W-1:0] OP_SNP_RSP  = 3'd4;
	localparam logic [OPC_W-1:0] OP_COLLECT  = 3'd5;
	localparam logic [OPC_W-1:0] OP_TICK     = 3'd6;
	localparam logic [OPC_W-1:0] OP_CLEAR    = 3'd7;

	localparam logic [KIND_W-1:0] RK_SEND_ACK  = 2'd0;
	localparam logic [KIND_W-1:0] RK_DELIVERED = 2'd1;
	localparam logic [KIND_W-1:0] RK_NONE      = 2'd2;
	localparam logic [KIND_W-1:0] RK_DONE      = 2'd3;

	localparam logic [REGI_W-1:0] REG_REQ_LAT  = 2'd0;
	localparam logic [REGI_W-1:0] REG_RSP_LAT  = 2'd1;
	localparam logic [REGI_W-1:0] REG_DATA_LAT = 2'd2;
	localparam logic [REGI_W-1:0] REG_SNP_LAT  = 2'd3;

	typedef enum logic [1:0] {
		CMD_SEND,
		CMD_COLLECT,
		CMD_TICK,
		CMD_CLEAR
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t          kind;
		logic [CLS_W-1:0]   cls;
		logic [LAT_W-1:0]   lat;
		logic [DEST_W-1:0]  dest;
		logic [PAY_W-1:0]   payload;
	} cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_COLLECT
	} bstate_t;

endpackage

`default_nettype wire

>>> src/tmdq_front.sv
// Front end of the timed message delay queue: latency registers, opcode decode and a
// two-entry command queue toward the back end. Depends on tmdq_pkg.
`default_nettype none

module tmdq_front import tmdq_pkg::*; (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [OPC_W-1:0]   opcode,
	input  wire logic [DEST_W-1:0]  dest_node,
	input  wire logic [PAY_W-1:0]   message_payload,
	input  wire logic               wr_en,
	input  wire logic [REGI_W-1:0]  wr_index,
	input  wire logic [LAT_W-1:0]   wr_data,
	output logic                    cmd_valid,
	input  wire logic               cmd_take,
	output cmd_t                    cmd
);

	logic [LAT_W-1:0] req_lat_q, rsp_lat_q, data_lat_q, snp_lat_q;
	cmd_t             new_cmd;
	cmd_t             fifo_q [2];
	logic             wr_ptr_q, rd_ptr_q;
	logic [1:0]       fill_q;
	logic             push, pop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_lat_q  <= LAT_W'(1);
			rsp_lat_q  <= LAT_W'(1);
			data_lat_q <= LAT_W'(1);
			snp_lat_q  <= LAT_W'(1);
		end else if (wr_en) begin
			case (wr_index)
				REG_REQ_LAT:  req_lat_q  <= wr_data;
				REG_RSP_LAT:  rsp_lat_q  <= wr_data;
				REG_DATA_LAT: data_lat_q <= wr_data;
				REG_SNP_LAT:  snp_lat_q  <= wr_data;
				default: ;
			endcase
		end
	end

	always_comb begin
		new_cmd.kind    = CMD_SEND;
		new_cmd.cls     = '0;
		new_cmd.lat     = '0;
		new_cmd.dest    = dest_node;
		new_cmd.payload = message_payload;
		case (opcode)
			OP_REQUEST: begin
				new_cmd.cls = opcode;
				new_cmd.lat = req_lat_q;
			end
			OP_RESPONSE: begin
				new_cmd.cls = opcode;
				new_cmd.lat = rsp_lat_q;
			end
			OP_DATA: begin
				new_cmd.cls = opcode;
				new_cmd.lat = data_lat_q;
			end
			OP_SNOOP, OP_SNP_RSP: begin
				new_cmd.cls = opcode;
				new_cmd.lat = snp_lat_q;
			end
			OP_COLLECT: new_cmd.kind = CMD_COLLECT;
			OP_TICK:    new_cmd.kind = CMD_TICK;
			OP_CLEAR:   new_cmd.kind = CMD_CLEAR;
			default:    new_cmd.kind = CMD_CLEAR;
		endcase
	end

	assign in_stall  = (fill_q == 2'd2);
	assign cmd_valid = (fill_q != 2'd0);
	assign push      = in_valid && !in_stall;
	assign pop       = cmd_take && cmd_valid;
	assign cmd       = fifo_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (push) wr_ptr_q <= !wr_ptr_q;
			if (pop)  rd_ptr_q <= !rd_ptr_q;
			if (push && !pop)      fill_q <= fill_q + 2'd1;
			else if (pop && !push) fill_q <= fill_q - 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (push) fifo_q[wr_ptr_q] <= new_cmd;
	end

endmodule

`default_nettype wire

>>> src/tmdq_back.sv
// Back end of the timed message delay queue: message store, counters, cycle counter,
// collect sequencer and the result output register. Depends on tmdq_pkg.
`default_nettype none

module tmdq_back import tmdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cmd_valid,
	output logic                    cmd_take,
	input  wire cmd_t               cmd,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [KIND_W-1:0]       result_kind,
	output logic                    accepted,
	output logic [CLS_W-1:0]        out_class,
	output logic [DEST_W-1:0]       out_dest,
	output logic [PAY_W-1:0]        out_payload,
	output logic                    last_of_run,
	output logic [OCC_W-1:0]        occupancy,
	output logic [OCC_W-1:0]        peak_occupancy,
	output logic [CNT_W-1:0]        total_sent,
	output logic [CNT_W-1:0]        class_sent,
	output logic [TIME_W-1:0]       now_cycle
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	function automatic logic [AW-1:0] ptr_inc(input logic [AW-1:0] p);
		ptr_inc = (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
	endfunction

	logic [TIME_W-1:0] mem_due  [DEPTH];
	logic [CLS_W-1:0]  mem_cls  [DEPTH];
	logic [DEST_W-1:0] mem_dest [DEPTH];
	logic [PAY_W-1:0]  mem_pay  [DEPTH];

	logic [TIME_W-1:0] rd_due_q;
	logic [CLS_W-1:0]  rd_cls_q;
	logic [DEST_W-1:0] rd_dest_q;
	logic [PAY_W-1:0]  rd_pay_q;

	bstate_t           state_q, state_d;
	logic [AW-1:0]     head_q, tail_q;
	logic [CW-1:0]     count_q, peak_q;
	logic [TIME_W-1:0] now_q;
	logic [CNT_W-1:0]  total_q;
	logic [CNT_W-1:0]  cls_cnt_q [NUM_CLS];

	logic              pend_v_q;
	logic [CLS_W-1:0]  pend_cls_q;
	logic [DEST_W-1:0] pend_dest_q;
	logic [PAY_W-1:0]  pend_pay_q;
	logic [CW-1:0]     pend_occ_q;
	logic [CNT_W-1:0]  pend_csent_q;

	logic              out_valid_q, out_acc_q, out_last_q;
	logic [KIND_W-1:0] out_kind_q;
	logic [CLS_W-1:0]  out_cls_q;
	logic [DEST_W-1:0] out_dest_q;
	logic [PAY_W-1:0]  out_pay_q;
	logic [OCC_W-1:0]  out_occ_q, out_peak_q;
	logic [CNT_W-1:0]  out_total_q, out_csent_q;
	logic [TIME_W-1:0] out_now_q;

	logic              out_free, full, head_due;
	logic [CLS_W-1:0]  rd_cls_fix, cnt_idx;
	logic [CNT_W-1:0]  cnt_rd;
	logic [CW-1:0]     count_inc, peak_inc;

	logic              do_send, do_tick, do_clear, do_pop, rd_en, load_out, pend_load, pend_clr;
	logic [AW-1:0]     rd_addr;
	logic              o_acc, o_last;
	logic [KIND_W-1:0] o_kind;
	logic [CLS_W-1:0]  o_cls;
	logic [DEST_W-1:0] o_dest;
	logic [PAY_W-1:0]  o_pay;
	logic [CW-1:0]     o_occ, o_peak;
	logic [CNT_W-1:0]  o_total, o_csent;
	logic [TIME_W-1:0] o_now;

	assign out_free   = !out_valid_q || !out_stall;
	assign full       = (count_q == CW'(DEPTH));
	assign head_due   = (count_q != '0) && (rd_due_q <= now_q);
	assign rd_cls_fix = (rd_cls_q < CLS_W'(NUM_CLS)) ? rd_cls_q : '0;
	assign cnt_idx    = (state_q == ST_COLLECT) ? rd_cls_fix : cmd.cls;
	assign cnt_rd     = cls_cnt_q[cnt_idx];
	assign count_inc  = count_q + 1'b1;
	assign peak_inc   = (count_inc > peak_q) ? count_inc : peak_q;

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free && cmd.kind == CMD_COLLECT) state_d = ST_COLLECT;
			end
			ST_COLLECT: begin
				if (!head_due && out_free) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd_take  = 1'b0;
		do_send   = 1'b0;
		do_tick   = 1'b0;
		do_clear  = 1'b0;
		do_pop    = 1'b0;
		rd_en     = 1'b0;
		rd_addr   = head_q;
		load_out  = 1'b0;
		pend_load = 1'b0;
		pend_clr  = 1'b0;
		o_kind    = RK_DONE;
		o_acc     = 1'b0;
		o_cls     = '0;
		o_dest    = '0;
		o_pay     = '0;
		o_last    = 1'b1;
		o_occ     = count_q;
		o_peak    = peak_q;
		o_total   = total_q;
		o_csent   = '0;
		o_now     = now_q;
		case (state_q)
			ST_IDLE: begin
				if (cmd_valid && out_free) begin
					cmd_take = 1'b1;
					case (cmd.kind)
						CMD_SEND: begin
							load_out = 1'b1;
							o_kind   = RK_SEND_ACK;
							o_cls    = cmd.cls;
							o_csent  = cnt_rd;
							if (!full) begin
								do_send = 1'b1;
								o_acc   = 1'b1;
								o_occ   = count_inc;
								o_peak  = peak_inc;
								o_total = total_q + 1'b1;
								o_csent = cnt_rd + 1'b1;
							end
						end
						CMD_TICK: begin
							load_out = 1'b1;
							do_tick  = 1'b1;
							o_now    = now_q + 1'b1;
						end
						CMD_CLEAR: begin
							load_out = 1'b1;
							do_clear = 1'b1;
							o_occ    = '0;
						end
						CMD_COLLECT: begin
							rd_en    = 1'b1;
							pend_clr = 1'b1;
						end
						default: ;
					endcase
				end
			end
			ST_COLLECT: begin
				o_kind  = RK_DELIVERED;
				o_cls   = pend_cls_q;
				o_dest  = pend_dest_q;
				o_pay   = pend_pay_q;
				o_occ   = pend_occ_q;
				o_csent = pend_csent_q;
				if (head_due) begin
					if (!pend_v_q || out_free) begin
						load_out  = pend_v_q;
						o_last    = 1'b0;
						do_pop    = 1'b1;
						pend_load = 1'b1;
						rd_en     = 1'b1;
						rd_addr   = ptr_inc(head_q);
					end
				end else if (out_free) begin
					load_out = 1'b1;
					pend_clr = 1'b1;
					if (!pend_v_q) begin
						o_kind = RK_NONE;
						o_cls  = '0;
						o_dest = '0;
						o_pay  = '0;
						o_occ  = count_q;
						o_csent = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (do_send) begin
			mem_due[tail_q]  <= now_q + TIME_W'(cmd.lat);
			mem_cls[tail_q]  <= cmd.cls;
			mem_dest[tail_q] <= cmd.dest;
			mem_pay[tail_q]  <= cmd.payload;
		end
		if (rd_en) begin
			rd_due_q  <= mem_due[rd_addr];
			rd_cls_q  <= mem_cls[rd_addr];
			rd_dest_q <= mem_dest[rd_addr];
			rd_pay_q  <= mem_pay[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			peak_q  <= '0;
			now_q   <= '0;
			total_q <= '0;
			for (int i = 0; i < NUM_CLS; i++) cls_cnt_q[i] <= '0;
			pend_v_q    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (do_send) begin
				tail_q             <= ptr_inc(tail_q);
				count_q            <= count_inc;
				peak_q             <= peak_inc;
				total_q            <= total_q + 1'b1;
				cls_cnt_q[cmd.cls] <= cnt_rd + 1'b1;
			end
			if (do_tick) now_q <= now_q + 1'b1;
			if (do_clear) begin
				head_q  <= '0;
				tail_q  <= '0;
				count_q <= '0;
			end
			if (do_pop) begin
				head_q  <= ptr_inc(head_q);
				count_q <= count_q - 1'b1;
			end
			if (pend_load)     pend_v_q <= 1'b1;
			else if (pend_clr) pend_v_q <= 1'b0;
			if (load_out)       out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_load) begin
			pend_cls_q   <= rd_cls_fix;
			pend_dest_q  <= rd_dest_q;
			pend_pay_q   <= rd_pay_q;
			pend_occ_q   <= count_q - 1'b1;
			pend_csent_q <= cnt_rd;
		end
		if (load_out) begin
			out_kind_q  <= o_kind;
			out_acc_q   <= o_acc;
			out_cls_q   <= o_cls;
			out_dest_q  <= o_dest;
			out_pay_q   <= o_pay;
			out_last_q  <= o_last;
			out_occ_q   <= OCC_W'(o_occ);
			out_peak_q  <= OCC_W'(o_peak);
			out_total_q <= o_total;
			out_csent_q <= o_csent;
			out_now_q   <= o_now;
		end
	end

	assign out_valid      = out_valid_q;
	assign result_kind    = out_kind_q;
	assign accepted       = out_acc_q;
	assign out_class      = out_cls_q;
	assign out_dest       = out_dest_q;
	assign out_payload    = out_pay_q;
	assign last_of_run    = out_last_q;
	assign occupancy      = out_occ_q;
	assign peak_occupancy = out_peak_q;
	assign total_sent     = out_total_q;
	assign class_sent     = out_csent_q;
	assign now_cycle      = out_now_q;

endmodule

`default_nettype wire

>>> src/timed_message_delay_queue_core.sv
// Top level of the timed message delay queue: joins the decode front end and the
// execution back end. Depends on tmdq_pkg, tmdq_front and tmdq_back.
//
//   Channel   Direction  Handshake            Beat contents
//   input     in         in_valid / in_stall  opcode, dest_node, message_payload
//   result    out        out_valid/out_stall  result_kind .. now_cycle, one result each
//   config    in         wr_en                wr_index, wr_data (no read-back)
//
// A beat is registered in the command queue; sends, ticks and clears then give their result at
// the edge the back end takes them, so they run at one per cycle while the output is not stalled.
// A collect first reads the head entry, then pops one due message per cycle while the output is
// not stalled, and a beat is loaded once the entry behind it is checked.
// Reset clears pointers, counters, the cycle counter and latencies (to one); no clear pass.
// An output stall holds the back end; the command queue takes up to two beats meanwhile.
`default_nettype none

module timed_message_delay_queue_core import tmdq_pkg::*; #(
	parameter int DEPTH = 16
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [OPC_W-1:0]   opcode,
	input  wire logic [DEST_W-1:0]  dest_node,
	input  wire logic [PAY_W-1:0]   message_payload,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [KIND_W-1:0]       result_kind,
	output logic                    accepted,
	output logic [CLS_W-1:0]        out_class,
	output logic [DEST_W-1:0]       out_dest,
	output logic [PAY_W-1:0]        out_payload,
	output logic                    last_of_run,
	output logic [OCC_W-1:0]        occupancy,
	output logic [OCC_W-1:0]        peak_occupancy,
	output logic [CNT_W-1:0]        total_sent,
	output logic [CNT_W-1:0]        class_sent,
	output logic [TIME_W-1:0]       now_cycle,
	input  wire logic               wr_en,
	input  wire logic [REGI_W-1:0]  wr_index,
	input  wire logic [LAT_W-1:0]   wr_data
);

	logic cmd_valid, cmd_take;
	cmd_t cmd;

	tmdq_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.in_valid        (in_valid),
		.in_stall        (in_stall),
		.opcode          (opcode),
		.dest_node       (dest_node),
		.message_payload (message_payload),
		.wr_en           (wr_en),
		.wr_index        (wr_index),
		.wr_data         (wr_data),
		.cmd_valid       (cmd_valid),
		.cmd_take        (cmd_take),
		.cmd             (cmd)
	);

	tmdq_back #(
		.DEPTH (DEPTH)
	) u_back (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd_valid      (cmd_valid),
		.cmd_take       (cmd_take),
		.cmd            (cmd),
		.out_valid      (out_valid),
		.out_stall      (out_stall),
		.result_kind    (result_kind),
		.accepted       (accepted),
		.out_class      (out_class),
		.out_dest       (out_dest),
		.out_payload    (out_payload),
		.last_of_run    (last_of_run),
		.occupancy      (occupancy),
		.peak_occupancy (peak_occupancy),
		.total_sent     (total_sent),
		.class_sent     (class_sent),
		.now_cycle      (now_cycle)
	);

endmodule

`default_nettype wire
